[src/pfm_pkg.sv]
`timescale 1ns / 1ps
package pfm_pkg;

   localparam int ELEM_W = 16;
   localparam int EXP_W = 31;
   localparam int ACT_W = 3;
   localparam int STEP_W = $clog2(2 * ELEM_W + 1);
   localparam logic [ELEM_W-1:0] MODULUS_RESET = ELEM_W'(5);

   typedef enum logic [ACT_W-1:0] {
      ACT_ADD  = 3'd0,
      ACT_SUB  = 3'd1,
      ACT_MUL  = 3'd2,
      ACT_NEG  = 3'd3,
      ACT_EQ   = 3'd4,
      ACT_POW  = 3'd5,
      ACT_DIV  = 3'd6,
      ACT_NONE = 3'd7
   } action_type;

   typedef enum logic [2:0] {
      DST_A,
      DST_B,
      DST_ACC,
      DST_SQ,
      DST_RES
   } dest_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_RA,
      S_RA_W,
      S_RB,
      S_RB_W,
      S_SETUP,
      S_LOOP,
      S_ACC,
      S_ACC_W,
      S_SQ,
      S_SQ_W,
      S_FIN,
      S_FIN_W,
      S_RESP
   } state_type;

   typedef struct packed {
      logic [ACT_W-1:0]  action;
      logic [ELEM_W-1:0] operand_a;
      logic [ELEM_W-1:0] operand_b;
      logic [EXP_W-1:0]  exponent;
   } req_type;

   typedef struct packed {
      logic [ELEM_W-1:0] result;
      logic              is_equal;
   } rsp_type;

   typedef struct packed {
      logic     load;
      logic     mul_start;
      dest_type dest;
      logic     setup;
      logic     copy_acc;
   } cmd_type;

   typedef struct packed {
      logic       mul_done;
      logic       e_zero;
      logic       e_lsb;
      logic       b_zero;
      action_type act;
   } status_type;

endpackage

[src/pfm_mulmod.sv]
`timescale 1ns / 1ps
module pfm_mulmod
   import pfm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [ELEM_W-1:0] x,
   input  logic [ELEM_W-1:0] y,
   input  logic [ELEM_W-1:0] p,
   output logic              done,
   output logic [ELEM_W-1:0] prod
);

   localparam logic [STEP_W-1:0] STEPS = STEP_W'(2 * ELEM_W);

   logic [2*ELEM_W-1:0] prod_ff, prod_in;
   logic [ELEM_W-1:0]   rem_ff, rem_in;
   logic [STEP_W-1:0]   cnt_ff, cnt_in;
   logic                run_ff, run_in;
   logic                done_ff, done_in;
   logic [ELEM_W:0]     t;
   logic [ELEM_W:0]     diff;

   // restoring reduction, one product bit per cycle
   always_comb begin
      t = {rem_ff, prod_ff[2*ELEM_W-1]};
      diff = t - {1'b0, p};
      prod_in = prod_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      done_in = 1'b0;
      if (start) begin
         prod_in = (2*ELEM_W)'(x) * (2*ELEM_W)'(y);
         rem_in = '0;
         cnt_in = STEPS;
         run_in = 1'b1;
      end else if (run_ff) begin
         prod_in = {prod_ff[2*ELEM_W-2:0], 1'b0};
         rem_in = (t >= {1'b0, p}) ? diff[ELEM_W-1:0] : t[ELEM_W-1:0];
         cnt_in = cnt_ff - STEP_W'(1);
         if (cnt_ff == STEP_W'(1)) begin
            run_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign prod = (p < ELEM_W'(2)) ? '0 : rem_ff;

endmodule

[src/pfm_datapath.sv]
`timescale 1ns / 1ps
module pfm_datapath
   import pfm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [ELEM_W-1:0] csr_wdata,
   input  req_type           req_data,
   input  cmd_type           cmd,
   output status_type        status,
   output rsp_type           rsp_data
);

   logic [ELEM_W-1:0] p_ff, p_in;
   req_type           in_ff, in_in;
   logic [ELEM_W-1:0] a_ff, a_in, b_ff, b_in, acc_ff, acc_in, sq_ff, sq_in, res_ff, res_in;
   logic [EXP_W-1:0]  e_ff, e_in;
   logic              eq_ff, eq_in;
   dest_type          dest_ff, dest_in;

   logic [ELEM_W-1:0] mx, my, mprod;
   logic              mdone;
   logic [ELEM_W:0]   sum, dsum, dif, ddif;
   action_type        act;
   logic              p_degen;

   assign act = action_type'(in_ff.action);
   assign p_degen = p_ff < ELEM_W'(2);

   pfm_mulmod u_mulmod (
      .clock (clock),
      .reset (reset),
      .start (cmd.mul_start),
      .x     (mx),
      .y     (my),
      .p     (p_ff),
      .done  (mdone),
      .prod  (mprod)
   );

   always_comb begin
      unique case (cmd.dest)
         DST_A: begin
            mx = in_ff.operand_a;
            my = ELEM_W'(1);
         end
         DST_B: begin
            mx = in_ff.operand_b;
            my = ELEM_W'(1);
         end
         DST_ACC: begin
            mx = acc_ff;
            my = sq_ff;
         end
         DST_SQ: begin
            mx = sq_ff;
            my = sq_ff;
         end
         DST_RES: begin
            mx = a_ff;
            my = acc_ff;
         end
         default: begin
            mx = '0;
            my = '0;
         end
      endcase
   end

   always_comb begin
      sum = {1'b0, a_ff} + {1'b0, b_ff};
      dsum = sum - {1'b0, p_ff};
      dif = {1'b0, a_ff} + {1'b0, p_ff} - {1'b0, b_ff};
      ddif = dif - {1'b0, p_ff};
      p_in = csr_we ? csr_wdata : p_ff;
      in_in = cmd.load ? req_data : in_ff;
      a_in = a_ff;
      b_in = b_ff;
      acc_in = acc_ff;
      sq_in = sq_ff;
      e_in = e_ff;
      res_in = res_ff;
      eq_in = eq_ff;
      dest_in = cmd.mul_start ? cmd.dest : dest_ff;
      if (mdone) begin
         unique case (dest_ff)
            DST_A: a_in = mprod;
            DST_B: b_in = mprod;
            DST_ACC: acc_in = mprod;
            DST_SQ: begin
               sq_in = mprod;
               e_in = e_ff >> 1;
            end
            DST_RES: res_in = mprod;
            default: res_in = res_ff;
         endcase
      end
      if (cmd.setup) begin
         acc_in = (act == ACT_MUL) ? b_ff : ELEM_W'(1);
         sq_in = (act == ACT_POW) ? a_ff : b_ff;
         e_in = (act == ACT_POW) ? in_ff.exponent : EXP_W'(p_ff - ELEM_W'(2));
         eq_in = 1'b0;
         res_in = '0;
         unique case (act)
            ACT_ADD: res_in = (sum >= {1'b0, p_ff}) ? dsum[ELEM_W-1:0] : sum[ELEM_W-1:0];
            ACT_SUB: res_in = (dif >= {1'b0, p_ff}) ? ddif[ELEM_W-1:0] : dif[ELEM_W-1:0];
            ACT_NEG: res_in = (a_ff == '0) ? '0 : p_ff - a_ff;
            ACT_EQ: eq_in = (a_ff == b_ff);
            default: res_in = '0;
         endcase
      end
      if (cmd.copy_acc) begin
         res_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      in_ff <= in_in;
      a_ff <= a_in;
      b_ff <= b_in;
      acc_ff <= acc_in;
      sq_ff <= sq_in;
      e_ff <= e_in;
      res_ff <= res_in;
      eq_ff <= eq_in;
      dest_ff <= dest_in;
      if (reset) begin
         p_ff <= MODULUS_RESET;
      end else begin
         p_ff <= p_in;
      end
   end

   assign status.mul_done = mdone;
   assign status.e_zero = (e_ff == '0);
   assign status.e_lsb = e_ff[0];
   assign status.b_zero = (b_ff == '0);
   assign status.act = act;
   assign rsp_data.result = p_degen ? '0 : res_ff;
   assign rsp_data.is_equal = eq_ff;

endmodule

[src/pfm_ctrl.sv]
`timescale 1ns / 1ps
module pfm_ctrl
   import pfm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (req_valid) state_in = S_RA;
         S_RA: state_in = S_RA_W;
         S_RA_W: if (status.mul_done) state_in = S_RB;
         S_RB: state_in = S_RB_W;
         S_RB_W: if (status.mul_done) state_in = S_SETUP;
         S_SETUP: begin
            unique case (status.act)
               ACT_MUL: state_in = S_FIN;
               ACT_POW: state_in = S_LOOP;
               ACT_DIV: state_in = status.b_zero ? S_RESP : S_LOOP;
               default: state_in = S_RESP;
            endcase
         end
         S_LOOP: begin
            priority if (status.e_zero) begin
               state_in = (status.act == ACT_POW) ? S_RESP : S_FIN;
            end else if (status.e_lsb) begin
               state_in = S_ACC;
            end else begin
               state_in = S_SQ;
            end
         end
         S_ACC: state_in = S_ACC_W;
         S_ACC_W: if (status.mul_done) state_in = S_SQ;
         S_SQ: state_in = S_SQ_W;
         S_SQ_W: if (status.mul_done) state_in = S_LOOP;
         S_FIN: state_in = S_FIN_W;
         S_FIN_W: if (status.mul_done) state_in = S_RESP;
         S_RESP: if (rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.dest = DST_A;
      req_ready = (state_ff == S_IDLE);
      rsp_valid = (state_ff == S_RESP);
      cmd.load = req_valid && req_ready;
      unique case (state_ff)
         S_RA: cmd.mul_start = 1'b1;
         S_RB: begin
            cmd.mul_start = 1'b1;
            cmd.dest = DST_B;
         end
         S_ACC: begin
            cmd.mul_start = 1'b1;
            cmd.dest = DST_ACC;
         end
         S_SQ: begin
            cmd.mul_start = 1'b1;
            cmd.dest = DST_SQ;
         end
         S_FIN: begin
            cmd.mul_start = 1'b1;
            cmd.dest = DST_RES;
         end
         S_SETUP: cmd.setup = 1'b1;
         S_LOOP: cmd.copy_acc = status.e_zero && (status.act == ACT_POW);
         default: cmd.setup = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[src/prime_field_modular_alu_unit.sv]
`timescale 1ns / 1ps
// channel | ports                      | beat
// req     | req_valid/req_ready        | req_data: action, operand_a, operand_b, exponent
// rsp     | rsp_valid/rsp_ready        | rsp_data: result, is_equal
// csr     | csr_valid/csr_ready        | csr_data: modulus p (reset 5)
// One item at a time; every modular multiply runs in the shared
// bit-serial reduction unit, and two input reductions open every item.
// After those, add/sub/neg/eq are computed in the setup step and mul does one multiply;
// power squares once per exponent bit through the top set bit and multiplies once per set bit;
// divide does likewise over p-2 plus a last multiply by a (none when b is zero).
// Reset is synchronous; the result holds on rsp until taken, req stalls meanwhile.
module prime_field_modular_alu_unit
   import pfm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [ELEM_W-1:0] csr_data
);

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   pfm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   pfm_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_valid && csr_ready),
      .csr_wdata (csr_data),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_data)
   );

endmodule
